// ----- design/crsa_pkg.sv -----
// Shared widths, result status codes and ring control type for the slot allocator.
package crsa_pkg;

    localparam int REQ_W    = 7;
    localparam int SLOT_W   = 7;
    localparam int STATUS_W = 2;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_RUN     = 2'd0;
    localparam t_status ST_SCATTER = 2'd1;
    localparam t_status ST_FAIL    = 2'd2;

    // Control handed from the sequencer to the ring of cells.
    typedef struct packed {
        logic shift;  // rotate every cell one place toward the head
        logic mark;   // write the head slot back as occupied
    } t_ring_ctl;

endpackage

// ----- design/crsa_ifs.sv -----
// Valid/ready channel interfaces for requests and results.
interface crsa_req_if;
    logic                        valid;
    logic                        ready;
    logic [crsa_pkg::REQ_W-1:0]  request_size;

    modport source (output valid, output request_size, input ready);
    modport sink   (input valid, input request_size, output ready);
endinterface

interface crsa_res_if;
    logic                           valid;
    logic                           ready;
    logic [crsa_pkg::SLOT_W-1:0]    slot_index;
    logic [crsa_pkg::STATUS_W-1:0]  status;
    logic                           last_of_request;

    modport source (output valid, output slot_index, output status, output last_of_request,
                    input ready);
    modport sink   (input valid, input slot_index, input status, input last_of_request,
                    output ready);
endinterface

// ----- design/crsa_cell.sv -----
// One slot of the occupancy ring: holds the slot's occupied bit and passes it on.
module crsa_cell (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_shift,
    input  logic i_bit,
    output logic o_bit
);

    logic r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 1'b0;
        end else if (i_shift) begin
            r_bit <= i_bit;
        end
    end

    assign o_bit = r_bit;

endmodule

// ----- design/crsa_ctrl.sv -----
// Sequencer: watches the ring head, runs the first-fit search lap and the grant lap.
module crsa_ctrl #(
    parameter int SLOTS       = 128,
    parameter int MAX_REQUEST = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_head,
    output crsa_pkg::t_ring_ctl o_ring,
    crsa_req_if.sink            i_req,
    crsa_res_if.source          o_res
);

    localparam int PW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LW = (MAX_REQUEST > 1) ? $clog2(MAX_REQUEST + 1) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FILL,
        S_FAIL
    } t_state;

    t_state                    r_state, n_state;
    logic [PW-1:0]             r_pos, n_pos;
    logic [PW-1:0]             r_start, n_start;
    logic [LW-1:0]             r_run, n_run;
    logic [LW-1:0]             r_len, n_len;
    logic [LW-1:0]             r_cnt, n_cnt;
    logic                      r_found, n_found;
    logic                      r_out_valid, n_out_valid;
    logic [crsa_pkg::SLOT_W-1:0] r_slot, n_slot;
    crsa_pkg::t_status         r_status, n_status;
    logic                      r_last, n_last;

    logic                      w_out_free;
    logic                      w_at_end;
    logic                      w_want;
    logic [LW:0]               w_run_inc;
    logic [LW:0]               w_cnt_inc;
    logic [LW:0]               w_len_ext;
    logic [LW-1:0]             w_req_len;
    logic [PW-1:0]             w_pos_inc;
    logic [PW-1:0]             w_start;
    logic [PW+6:0]             w_pos_ext;
    crsa_pkg::t_ring_ctl       w_ring;

    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_at_end   = (r_pos == PW'(SLOTS - 1));
    assign w_pos_inc  = w_at_end ? '0 : PW'(r_pos + 1'b1);
    assign w_run_inc  = (LW+1)'(r_run) + 1'b1;
    assign w_cnt_inc  = (LW+1)'(r_cnt) + 1'b1;
    assign w_len_ext  = (LW+1)'(r_len);
    assign w_start    = PW'(32'(r_pos) + 32'd1 - 32'(r_len));
    assign w_pos_ext  = (PW+7)'(r_pos);

    // Saturate oversized requests.
    assign w_req_len = (i_req.request_size > crsa_pkg::REQ_W'(MAX_REQUEST)) ?
                       LW'(MAX_REQUEST) : LW'(i_req.request_size);

    // Head slot is granted: inside the found run, or any free slot when scattering.
    assign w_want = (r_cnt != r_len) && (r_found ? (r_pos >= r_start) : !i_head);

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_start     = r_start;
        n_run       = r_run;
        n_len       = r_len;
        n_cnt       = r_cnt;
        n_found     = r_found;
        n_out_valid = r_out_valid && !o_res.ready;
        n_slot      = r_slot;
        n_status    = r_status;
        n_last      = r_last;
        w_ring      = '0;

        case (r_state)
            S_IDLE: begin
                if (i_req.valid && (i_req.request_size != '0)) begin
                    n_len   = w_req_len;
                    n_run   = '0;
                    n_found = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                w_ring.shift = 1'b1;
                n_pos        = w_pos_inc;
                if (!r_found) begin
                    if (i_head) begin
                        n_run = '0;
                    end else if (w_run_inc == w_len_ext) begin
                        n_found = 1'b1;
                        n_start = w_start;
                    end else begin
                        n_run = LW'(w_run_inc);
                    end
                end
                if (w_at_end) begin
                    n_cnt   = '0;
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                // Hold the ring while a grant waits for the result register.
                if (!w_want || w_out_free) begin
                    w_ring.shift = 1'b1;
                    n_pos        = w_pos_inc;
                    if (w_want) begin
                        w_ring.mark = 1'b1;
                        n_cnt       = LW'(w_cnt_inc);
                        n_out_valid = 1'b1;
                        n_slot      = w_pos_ext[crsa_pkg::SLOT_W-1:0];
                        n_status    = r_found ? crsa_pkg::ST_RUN : crsa_pkg::ST_SCATTER;
                        n_last      = (w_cnt_inc == w_len_ext);
                    end
                    if (w_at_end) begin
                        n_state = ((LW+1)'(n_cnt) == w_len_ext) ? S_IDLE : S_FAIL;
                    end
                end
            end
            S_FAIL: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_slot      = '0;
                    n_status    = crsa_pkg::ST_FAIL;
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_run       <= '0;
            r_len       <= '0;
            r_cnt       <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_run       <= n_run;
            r_len       <= n_len;
            r_cnt       <= n_cnt;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
        r_start  <= n_start;
        r_slot   <= n_slot;
        r_status <= n_status;
        r_last   <= n_last;
    end

    assign o_ring               = w_ring;
    assign i_req.ready          = (r_state == S_IDLE);
    assign o_res.valid          = r_out_valid;
    assign o_res.slot_index     = r_slot;
    assign o_res.status         = r_status;
    assign o_res.last_of_request = r_last;

endmodule

// ----- design/contiguous_run_slot_allocator_top.sv -----
// First-fit contiguous slot allocator: top level with the rotating occupancy ring.
//
// The occupancy map lives in a ring of SLOTS one-bit cells that rotates toward
// the head cell; a sequencer watches only the head, so every nonzero request walks the
// ring. A request of size n (saturated to MAX_REQUEST) takes two full laps: the
// first lap finds the lowest free run of n slots, the second lap marks slots as
// they pass the head and emits one result transaction per granted slot, lowest
// index first (status 0 for a contiguous run, 1 for scattered grants when no
// run exists). If free slots run out, a final result with status 2, index 0 and
// last_of_request set follows the grants already made, which stay occupied.
// The ring rotation paces each nonzero request, and a grant that waits on a
// full result register holds the ring. A zero-size request is accepted
// without walking the ring and produces nothing. One request is in flight at
// a time.
module contiguous_run_slot_allocator_top #(
    parameter int SLOTS       = 128,
    parameter int MAX_REQUEST = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    crsa_req_if.sink   i_req,
    crsa_res_if.source o_res
);

    crsa_pkg::t_ring_ctl w_ring;
    logic [SLOTS-1:0]    w_bits;

    crsa_ctrl #(
        .SLOTS       (SLOTS),
        .MAX_REQUEST (MAX_REQUEST)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_bits[0]),
        .o_ring  (w_ring),
        .i_req   (i_req),
        .o_res   (o_res)
    );

    // Cell k takes the bit of cell k+1; the tail takes the head back, marked
    // occupied when the head slot is granted.
    for (genvar k = 0; k < SLOTS; k++) begin : g_cell
        logic w_in;
        if (k == SLOTS - 1) begin : g_tail
            assign w_in = w_bits[0] | w_ring.mark;
        end else begin : g_mid
            assign w_in = w_bits[k+1];
        end

        crsa_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_ring.shift),
            .i_bit   (w_in),
            .o_bit   (w_bits[k])
        );
    end

endmodule

// ----- design/crsa_checker.sv -----
// Port-level assertions for the slot allocator, bound to the top level.
module crsa_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_req_valid,
    input logic                           i_req_ready,
    input logic [crsa_pkg::REQ_W-1:0]     i_req_size,
    input logic                           i_res_valid,
    input logic                           i_res_ready,
    input logic [crsa_pkg::SLOT_W-1:0]    i_res_slot,
    input logic [crsa_pkg::STATUS_W-1:0]  i_res_status,
    input logic                           i_res_last
);

    // Come out of reset idle with no result pending.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (i_req_ready && !i_res_valid))
        else $error("allocator not idle after reset");

    // A nonzero request blocks the next one.
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready && (i_req_size != '0)) |=> !i_req_ready)
        else $error("request accepted while previous one in flight");

    // A failure result always carries index zero and ends the request.
    a_fail_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && (i_res_status == crsa_pkg::ST_FAIL)) |-> (i_res_slot == '0 && i_res_last))
        else $error("malformed failure result");

    // Hold a stalled result transaction.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=>
        (i_res_valid && $stable(i_res_slot) && $stable(i_res_status) && $stable(i_res_last)))
        else $error("stalled result changed");

endmodule

bind contiguous_run_slot_allocator_top crsa_checker u_crsa_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_req_size   (i_req.request_size),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_res_slot   (o_res.slot_index),
    .i_res_status (o_res.status),
    .i_res_last   (o_res.last_of_request)
);

// ----- verif/tb_contiguous_run_slot_allocator_top.sv -----
// Self-checking testbench for the first-fit contiguous slot allocator.
`timescale 1ns / 100ps

module tb_contiguous_run_slot_allocator_top;

    localparam int SLOTS          = 128;
    localparam int MAX_REQUEST    = 64;
    localparam int RANDOM_ITEMS   = 420;
    // One receiver hold-off, long enough to back the block up into the request side.
    localparam int HOLDOFF_CYCLES = 600;
    // Settle time after the last expected grant: one full request is two ring laps.
    localparam int DRAIN_CYCLES   = 2 * SLOTS + 16;
    // Hard limit on run time, well above the slowest correct run.
    localparam int RUN_LIMIT_NS   = 8_000_000;
    localparam int NUM_ROWS       = 14;

    // One result transaction as the block should emit it.
    typedef struct packed {
        logic [crsa_pkg::SLOT_W-1:0] slot_index;
        crsa_pkg::t_status           status;
        logic                        last_of_request;
    } t_grant;

    // One row of the directed plan; hand_typed rows carry their single expected result.
    typedef struct packed {
        logic [crsa_pkg::REQ_W-1:0] request_size;
        logic                       hand_typed;
        t_grant                     outcome;
    } t_plan_row;

    localparam t_grant NO_GRANT   = '0;
    localparam t_grant FAIL_GRANT = '{slot_index: '0, status: crsa_pkg::ST_FAIL,
                                      last_of_request: 1'b1};

    logic i_clk;
    logic i_rst_n;

    crsa_req_if req_if ();
    crsa_res_if res_if ();

    contiguous_run_slot_allocator_top #(
        .SLOTS       (SLOTS),
        .MAX_REQUEST (MAX_REQUEST)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    // Predictor state: our own copy of the occupancy map and the grants still owed.
    logic   slot_taken [SLOTS];
    t_grant grants_due [$];
    int     mismatch_count = 0;

    // Idle percentages for each side, changed between phases of the run.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Receiver hold-off bookkeeping.
    int holdoff_left = 0;
    bit holdoff_done = 1'b0;

    // Walk the map in the directed order: reset state, a few runs (one saturated),
    // then exhaustion partway through a scattered grant, then a full map.
    t_plan_row directed_plan [NUM_ROWS] = '{
        '{7'd0,   1'b0, NO_GRANT},                                  // zero size: nothing
        '{7'd1,   1'b1, '{7'd0, crsa_pkg::ST_RUN, 1'b1}},           // first grant after reset
        '{7'd2,   1'b0, NO_GRANT},
        '{7'd3,   1'b0, NO_GRANT},
        '{7'd127, 1'b0, NO_GRANT},                                  // saturates to a 64-slot run
        '{7'd8,   1'b0, NO_GRANT},
        '{7'd0,   1'b0, NO_GRANT},
        '{7'd65,  1'b0, NO_GRANT},                                  // no run left: scatter, then fail
        '{7'd1,   1'b1, FAIL_GRANT},                                // map full from here on
        '{7'd64,  1'b1, FAIL_GRANT},
        '{7'd127, 1'b1, FAIL_GRANT},
        '{7'd0,   1'b0, NO_GRANT},
        '{7'd2,   1'b1, FAIL_GRANT},
        '{7'd96,  1'b1, FAIL_GRANT}
    };

    // 10 ns clock.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic void push_grant(input int slot, input crsa_pkg::t_status st,
                                       input bit last);
        t_grant g;
        g.slot_index      = crsa_pkg::SLOT_W'(slot);
        g.status          = st;
        g.last_of_request = last;
        grants_due.push_back(g);
    endfunction

    // Work out the grants caused by one accepted request and update the map copy.
    function automatic void predict_allocation(input logic [crsa_pkg::REQ_W-1:0] size);
        int want;
        int run_len;
        int start;
        int got;
        int k;
        want = size;
        if (want == 0) return;                     // zero size: no result, no state change
        if (want > MAX_REQUEST) want = MAX_REQUEST;

        // Lowest-indexed run of want free slots.
        run_len = 0;
        start   = -1;
        for (k = 0; k < SLOTS; k++) begin
            if (!slot_taken[k]) begin
                run_len++;
                if (run_len == want && start < 0) start = k + 1 - want;
            end else begin
                run_len = 0;
            end
        end

        if (start >= 0) begin
            for (k = 0; k < want; k++) begin
                slot_taken[start + k] = 1'b1;
                push_grant(start + k, crsa_pkg::ST_RUN, k == want - 1);
            end
        end else begin
            // No run: take free slots one at a time, lowest first.
            got = 0;
            for (k = 0; k < SLOTS && got < want; k++) begin
                if (!slot_taken[k]) begin
                    slot_taken[k] = 1'b1;
                    got++;
                    push_grant(k, crsa_pkg::ST_SCATTER, got == want);
                end
            end
            if (got < want) push_grant(0, crsa_pkg::ST_FAIL, 1'b1);
        end
    endfunction

    // Offer one request, hold it until the block takes it, then record what it owes.
    task automatic offer_request(input logic [crsa_pkg::REQ_W-1:0] size,
                                 input logic hand_typed, input t_grant typed_grant);
        int gap;
        int depth;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.request_size <= size;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);

        depth = grants_due.size();
        predict_allocation(size);
        if (hand_typed) begin
            // Keep the map update, but check against the hand-typed result.
            while (grants_due.size() > depth) grants_due.delete(grants_due.size() - 1);
            grants_due.push_back(typed_grant);
        end
    endtask

    // Result side ready: one long hold-off on the first result, then random idling.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (holdoff_left != 0) begin
            holdoff_left <= holdoff_left - 1;
            res_if.ready <= 1'b0;
        end else if (!holdoff_done && res_if.valid) begin
            holdoff_done <= 1'b1;
            holdoff_left <= HOLDOFF_CYCLES;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each accepted result with the oldest grant still owed.
    always @(posedge i_clk) begin
        t_grant want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (grants_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result slot=%0d status=%0d last=%0b",
                                          res_if.slot_index, res_if.status,
                                          res_if.last_of_request));
            end else begin
                want = grants_due.pop_front();
                if (res_if.slot_index !== want.slot_index)
                    report_mismatch($sformatf("slot_index got %0d want %0d",
                                              res_if.slot_index, want.slot_index));
                if (res_if.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              res_if.status, want.status));
                if (res_if.last_of_request !== want.last_of_request)
                    report_mismatch($sformatf("last_of_request got %0b want %0b",
                                              res_if.last_of_request, want.last_of_request));
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        int sent;
        int row;
        logic [crsa_pkg::REQ_W-1:0] size;

        // Drive the request side and reset to known values before the first edge.
        i_rst_n             <= 1'b0;
        req_if.valid        <= 1'b0;
        req_if.request_size <= '0;

        for (row = 0; row < SLOTS; row++) slot_taken[row] = 1'b0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed plan: sender idles a third of the time, receiver most of it.
        send_idle_pct = 33;
        recv_idle_pct = 62;
        for (row = 0; row < NUM_ROWS; row++) begin
            offer_request(directed_plan[row].request_size, directed_plan[row].hand_typed,
                          directed_plan[row].outcome);
        end

        // Random sizes over the full field; zero-size requests do not count.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent == RANDOM_ITEMS / 3) begin
                send_idle_pct = 62;
                recv_idle_pct = 33;
            end else if (sent == 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            size = crsa_pkg::REQ_W'($urandom_range(127, 0));
            offer_request(size, 1'b0, NO_GRANT);
            if (size != 0) sent++;
        end
        req_if.valid <= 1'b0;

        // Drain what is owed, then give the block time to show any stray result.
        while (grants_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && grants_due.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Hard stop on a hung run.
    initial begin
        #(RUN_LIMIT_NS);
        $display("FAILURE");
        $finish;
    end

endmodule

// ----- files.f -----
design/crsa_pkg.sv
design/crsa_ifs.sv
design/crsa_cell.sv
design/crsa_ctrl.sv
design/contiguous_run_slot_allocator_top.sv
design/crsa_checker.sv
verif/tb_contiguous_run_slot_allocator_top.sv
